// ===== hw/rtl/ophp_pkg.sv =====
// ----------------------------------------------------------------------------
// ophp_pkg: shared definitions for the omni pose horizon predictor
// Widths, fixed-point constants, the CORDIC arctangent table and the control
// structures passed between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package ophp_pkg;

  localparam int POSE_W  = 32;  // Q15.16 pose words
  localparam int VEL_W   = 16;  // Q3.12 velocity words
  localparam int TS_W    = 16;  // Q0.16 time step
  localparam int YAW_W   = 33;  // wrapped heading, one bit of headroom
  localparam int VEC_W   = 35;  // CORDIC vector, Q3.28 with growth headroom
  localparam int ANG_W   = 48;  // CORDIC angle, Q2.30 with headroom
  localparam int ATAN_W  = 30;
  localparam int MUL_B_W = 17;  // multiplier second operand, signed
  localparam int ACC_W   = 66;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd6554;

  localparam logic signed [YAW_W-1:0] PI_Q16      = 33'sd205887;
  localparam logic signed [YAW_W-1:0] TWO_PI_Q16  = 33'sd411775;
  localparam logic signed [ANG_W-1:0] PI_Q30      = 48'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 48'sd1686629713;

  localparam longint GAIN_BASE_Q30 = 652032874;
  localparam longint GAIN_CORR     = 434688583;
  localparam longint GAIN_FULL     = GAIN_BASE_Q30 +
    ((GAIN_CORR + (longint'(1) << (2 * CORDIC_STEPS - 1))) >>> (2 * CORDIC_STEPS));
  localparam logic [ATAN_W-1:0] CORDIC_GAIN = GAIN_FULL[ATAN_W-1:0];

  typedef enum logic [1:0] {
    RND_Q30 = 2'd0,
    RND_Q28 = 2'd1,
    RND_Q12 = 2'd2
  } rnd_sel_t;

  typedef struct packed {
    logic     en;
    logic     clear;
    logic     shift_hi;
    rnd_sel_t rnd;
  } mac_ctrl_t;

  typedef struct packed {
    logic init;
    logic step;
  } cordic_ctrl_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:    v = 30'd843314857;
      5'd1:    v = 30'd497837829;
      5'd2:    v = 30'd263043837;
      5'd3:    v = 30'd133525159;
      5'd4:    v = 30'd67021687;
      5'd5:    v = 30'd33543516;
      5'd6:    v = 30'd16775851;
      5'd7:    v = 30'd8388437;
      5'd8:    v = 30'd4194283;
      5'd9:    v = 30'd2097149;
      5'd10:   v = 30'd1048576;
      5'd11:   v = 30'd524288;
      5'd12:   v = 30'd262144;
      5'd13:   v = 30'd131072;
      5'd14:   v = 30'd65536;
      5'd15:   v = 30'd32768;
      5'd16:   v = 30'd16384;
      5'd17:   v = 30'd8192;
      5'd18:   v = 30'd4096;
      5'd19:   v = 30'd2048;
      5'd20:   v = 30'd1024;
      5'd21:   v = 30'd512;
      5'd22:   v = 30'd256;
      5'd23:   v = 30'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/ophp_if.sv =====
// ----------------------------------------------------------------------------
// ophp_if: request and result channels of the pose predictor
// Valid/ready channels carrying one velocity command or one predicted pose.
// ----------------------------------------------------------------------------
interface ophp_cmd_if;
  import ophp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     load_start;
  logic signed [POSE_W-1:0] start_x;
  logic signed [POSE_W-1:0] start_y;
  logic signed [POSE_W-1:0] start_yaw;
  logic signed [VEL_W-1:0]  vel_forward;
  logic signed [VEL_W-1:0]  vel_lateral;
  logic signed [VEL_W-1:0]  turn_rate;
  logic                     last_command;

  modport source(output valid, load_start, start_x, start_y, start_yaw, vel_forward,
                 vel_lateral, turn_rate, last_command, input ready);
  modport sink(input valid, load_start, start_x, start_y, start_yaw, vel_forward,
               vel_lateral, turn_rate, last_command, output ready);
endinterface

interface ophp_pose_if;
  import ophp_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [POSE_W-1:0] pose_x;
  logic signed [POSE_W-1:0] pose_y;
  logic signed [POSE_W-1:0] pose_yaw;
  logic                     is_start_pose;
  logic                     last_pose;

  modport source(output valid, pose_x, pose_y, pose_yaw, is_start_pose, last_pose,
                 input ready);
  modport sink(input valid, pose_x, pose_y, pose_yaw, is_start_pose, last_pose,
               output ready);
endinterface

// ===== hw/rtl/ophp_cordic.sv =====
// ----------------------------------------------------------------------------
// ophp_cordic: iterative CORDIC rotator
// Rotates a body-frame velocity by the heading, one micro-rotation a cycle.
// ----------------------------------------------------------------------------
module ophp_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ophp_pkg::cordic_ctrl_t            ctrl,
  input  logic signed [ophp_pkg::VEL_W-1:0] vx,
  input  logic signed [ophp_pkg::VEL_W-1:0] vy,
  input  logic signed [ophp_pkg::YAW_W-1:0] yaw,
  output logic signed [ophp_pkg::VEC_W-1:0] x_out,
  output logic signed [ophp_pkg::VEC_W-1:0] y_out,
  output logic                              last_step
);
  import ophp_pkg::*;

  logic signed [VEC_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0] z_r, z_nxt;
  logic [STEP_W-1:0]       step_cnt_r, step_cnt_nxt;

  logic signed [ANG_W-1:0] z0;
  logic signed [VEC_W-1:0] x0, y0, xs, ys;
  logic signed [ANG_W-1:0] atan_ext;

  always_comb begin
    z0 = ANG_W'(yaw) <<< 14;
    x0 = VEC_W'(vx) <<< 16;
    y0 = VEC_W'(vy) <<< 16;
    xs = x_r >>> step_cnt_r;
    ys = y_r >>> step_cnt_r;
    atan_ext = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_q30(5'(step_cnt_r))});

    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    step_cnt_nxt = step_cnt_r;

    if (ctrl.init) begin
      step_cnt_nxt = '0;
      // Beyond a quarter turn the vector is first turned by half a turn.
      if (z0 > HALF_PI_Q30) begin
        z_nxt = z0 - PI_Q30;
        x_nxt = -x0;
        y_nxt = -y0;
      end else if (z0 < -HALF_PI_Q30) begin
        z_nxt = z0 + PI_Q30;
        x_nxt = -x0;
        y_nxt = -y0;
      end else begin
        z_nxt = z0;
        x_nxt = x0;
        y_nxt = y0;
      end
    end else if (ctrl.step) begin
      step_cnt_nxt = step_cnt_r + 1'b1;
      if (!z_r[ANG_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - atan_ext;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + atan_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    if (!rst_n) begin
      step_cnt_r <= '0;
    end else begin
      step_cnt_r <= step_cnt_nxt;
    end
  end

  assign x_out     = x_r;
  assign y_out     = y_r;
  assign last_step = (step_cnt_r == STEP_W'(CORDIC_STEPS - 1));

endmodule

// ===== hw/rtl/ophp_mac.sv =====
// ----------------------------------------------------------------------------
// ophp_mac: shared multiply-accumulate unit
// One signed multiplier feeding a wide accumulator that can be preset with a
// rounding constant; used for the gain correction and all three time-step scalings.
// ----------------------------------------------------------------------------
module ophp_mac (
  input  logic                                clk,
  input  ophp_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [ophp_pkg::VEC_W-1:0]   a,
  input  logic signed [ophp_pkg::MUL_B_W-1:0] b,
  output logic signed [ophp_pkg::ACC_W-1:0]   acc
);
  import ophp_pkg::*;

  localparam int PROD_W = VEC_W + MUL_B_W;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext, base;

  always_comb begin
    prod     = a * b;
    prod_ext = ACC_W'(prod);
    if (ctrl.shift_hi) begin
      prod_ext = prod_ext <<< 15;
    end
    case (ctrl.rnd)
      RND_Q30: base = ACC_W'(1) <<< 29;
      RND_Q28: base = ACC_W'(1) <<< 27;
      RND_Q12: base = ACC_W'(1) <<< 11;
      default: base = '0;
    endcase
    if (!ctrl.clear) begin
      base = acc_r;
    end
    acc_nxt = ctrl.en ? (base + prod_ext) : acc_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ===== hw/rtl/omni_pose_horizon_predictor_core.sv =====
// ----------------------------------------------------------------------------
// omni_pose_horizon_predictor_core: holonomic dead-reckoning pose predictor
// An accepted request runs through the heading wrap, CORDIC init, the 16 CORDIC
// iterations, seven passes through the one shared multiplier and the pose
// update; then the stepped pose is presented, after the echo of a start pose
// when one is loaded. A new request is taken only after that pose is emitted.
// Reset is synchronous and active low: pose cleared to zero, time step 6554.
// ----------------------------------------------------------------------------
module omni_pose_horizon_predictor_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ophp_pkg::TS_W-1:0]    cfg_wdata,
  ophp_cmd_if.sink                     in_cmd,
  ophp_pose_if.source                  out_pose
);
  import ophp_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_ECHO  = 14'b00000000000010,
    ST_WRAP  = 14'b00000000000100,
    ST_CINIT = 14'b00000000001000,
    ST_CSTEP = 14'b00000000010000,
    ST_GXL   = 14'b00000000100000,
    ST_GXH   = 14'b00000001000000,
    ST_GYL   = 14'b00000010000000,
    ST_GYH   = 14'b00000100000000,
    ST_DX    = 14'b00001000000000,
    ST_DY    = 14'b00010000000000,
    ST_DQ    = 14'b00100000000000,
    ST_UPD   = 14'b01000000000000,
    ST_EMIT  = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TS_W-1:0]          time_step_r, time_step_nxt;
  logic signed [POSE_W-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic signed [POSE_W-1:0] pose_yaw_r, pose_yaw_nxt;
  logic signed [YAW_W-1:0]  yaw_w_r, yaw_w_nxt;
  logic signed [VEL_W-1:0]  vx_r, vx_nxt, vy_r, vy_nxt, w_r, w_nxt;
  logic                     last_r, last_nxt;
  logic signed [VEC_W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [POSE_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic signed [POSE_W-1:0] out_yaw_r, out_yaw_nxt;
  logic                     out_start_r, out_start_nxt, out_last_r, out_last_nxt;

  cordic_ctrl_t              cordic_ctrl;
  logic signed [VEC_W-1:0]   cx, cy;
  logic                      cordic_last;
  mac_ctrl_t                 mac_ctrl;
  logic signed [VEC_W-1:0]   mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;

  logic                      in_fire, slot_free;
  logic signed [YAW_W-1:0]   yaw_ext;
  logic signed [MUL_B_W-1:0] gain_lo, gain_hi, ts_op;

  function automatic logic signed [POSE_W-1:0] sat_pose(input logic signed [POSE_W+1:0] v);
    logic signed [POSE_W-1:0] r;
    if ((v[POSE_W+1] == v[POSE_W]) && (v[POSE_W] == v[POSE_W-1])) begin
      r = v[POSE_W-1:0];
    end else begin
      r = {v[POSE_W+1], {(POSE_W-1){~v[POSE_W+1]}}};
    end
    return r;
  endfunction

  ophp_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (cordic_ctrl),
    .vx        (vx_r),
    .vy        (vy_r),
    .yaw       (yaw_w_r),
    .x_out     (cx),
    .y_out     (cy),
    .last_step (cordic_last)
  );

  ophp_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  assign in_fire   = in_cmd.valid & in_cmd.ready;
  assign slot_free = !out_valid_r | out_pose.ready;
  assign gain_lo   = $signed({2'b00, CORDIC_GAIN[14:0]});
  assign gain_hi   = $signed({2'b00, CORDIC_GAIN[29:15]});
  assign ts_op     = $signed({1'b0, time_step_r});
  assign yaw_ext   = YAW_W'(pose_yaw_r);

  always_comb begin
    state_nxt     = state_r;
    time_step_nxt = cfg_we ? cfg_wdata : time_step_r;
    pose_x_nxt    = pose_x_r;
    pose_y_nxt    = pose_y_r;
    pose_yaw_nxt  = pose_yaw_r;
    yaw_w_nxt     = yaw_w_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    w_nxt         = w_r;
    last_nxt      = last_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    out_valid_nxt = out_valid_r & ~out_pose.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_yaw_nxt   = out_yaw_r;
    out_start_nxt = out_start_r;
    out_last_nxt  = out_last_r;
    cordic_ctrl   = '0;
    mac_ctrl      = '{en: 1'b0, clear: 1'b0, shift_hi: 1'b0, rnd: RND_Q30};
    mac_a         = cx;
    mac_b         = gain_lo;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          vx_nxt   = in_cmd.vel_forward;
          vy_nxt   = in_cmd.vel_lateral;
          w_nxt    = in_cmd.turn_rate;
          last_nxt = in_cmd.last_command;
          if (in_cmd.load_start) begin
            pose_x_nxt   = in_cmd.start_x;
            pose_y_nxt   = in_cmd.start_y;
            pose_yaw_nxt = in_cmd.start_yaw;
            state_nxt    = ST_ECHO;
          end else begin
            state_nxt = ST_WRAP;
          end
        end
      end
      ST_ECHO: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pose_x_r;
          out_y_nxt     = pose_y_r;
          out_yaw_nxt   = pose_yaw_r;
          out_start_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_WRAP;
        end
      end
      ST_WRAP: begin
        // A single wrap; a heading beyond three half turns stays out of range.
        if (yaw_ext > PI_Q16) begin
          yaw_w_nxt = yaw_ext - TWO_PI_Q16;
        end else if (yaw_ext < -PI_Q16) begin
          yaw_w_nxt = yaw_ext + TWO_PI_Q16;
        end else begin
          yaw_w_nxt = yaw_ext;
        end
        state_nxt = ST_CINIT;
      end
      ST_CINIT: begin
        cordic_ctrl.init = 1'b1;
        state_nxt        = ST_CSTEP;
      end
      ST_CSTEP: begin
        cordic_ctrl.step = 1'b1;
        if (cordic_last) begin
          state_nxt = ST_GXL;
        end
      end
      // The gain is applied as two half-width partial products.
      ST_GXL: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0, rnd: RND_Q30};
        mac_a     = cx;
        mac_b     = gain_lo;
        state_nxt = ST_GXH;
      end
      ST_GXH: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1, rnd: RND_Q30};
        mac_a     = cx;
        mac_b     = gain_hi;
        state_nxt = ST_GYL;
      end
      ST_GYL: begin
        rx_nxt    = $signed(acc[VEC_W+29:30]);
        mac_ctrl  = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0, rnd: RND_Q30};
        mac_a     = cy;
        mac_b     = gain_lo;
        state_nxt = ST_GYH;
      end
      ST_GYH: begin
        mac_ctrl  = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1, rnd: RND_Q30};
        mac_a     = cy;
        mac_b     = gain_hi;
        state_nxt = ST_DX;
      end
      ST_DX: begin
        ry_nxt    = $signed(acc[VEC_W+29:30]);
        mac_ctrl  = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0, rnd: RND_Q28};
        mac_a     = rx_r;
        mac_b     = ts_op;
        state_nxt = ST_DY;
      end
      ST_DY: begin
        pose_x_nxt = sat_pose((POSE_W+2)'(pose_x_r) + (POSE_W+2)'($signed(acc[POSE_W+28:28])));
        mac_ctrl   = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0, rnd: RND_Q28};
        mac_a      = ry_r;
        mac_b      = ts_op;
        state_nxt  = ST_DQ;
      end
      ST_DQ: begin
        pose_y_nxt = sat_pose((POSE_W+2)'(pose_y_r) + (POSE_W+2)'($signed(acc[POSE_W+28:28])));
        mac_ctrl   = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0, rnd: RND_Q12};
        mac_a      = VEC_W'(w_r);
        mac_b      = ts_op;
        state_nxt  = ST_UPD;
      end
      ST_UPD: begin
        pose_yaw_nxt = sat_pose((POSE_W+2)'(yaw_w_r) +
                                (POSE_W+2)'($signed(acc[POSE_W+12:12])));
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = pose_x_r;
          out_y_nxt     = pose_y_r;
          out_yaw_nxt   = pose_yaw_r;
          out_start_nxt = 1'b0;
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    yaw_w_r     <= yaw_w_nxt;
    vx_r        <= vx_nxt;
    vy_r        <= vy_nxt;
    w_r         <= w_nxt;
    last_r      <= last_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_yaw_r   <= out_yaw_nxt;
    out_start_r <= out_start_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      time_step_r <= TIME_STEP_RST;
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      pose_yaw_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      time_step_r <= time_step_nxt;
      pose_x_r    <= pose_x_nxt;
      pose_y_r    <= pose_y_nxt;
      pose_yaw_r  <= pose_yaw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_cmd.ready           = (state_r == ST_IDLE);
  assign out_pose.valid         = out_valid_r;
  assign out_pose.pose_x        = out_x_r;
  assign out_pose.pose_y        = out_y_r;
  assign out_pose.pose_yaw      = out_yaw_r;
  assign out_pose.is_start_pose = out_start_r;
  assign out_pose.last_pose     = out_last_r;

endmodule
